// ----- rtl/core/sgpf_pkg.sv -----
// Shared constants for the spectral gain post-filter.
// Holds register indexes, register widths and reset values; no dependencies.
package sgpf_pkg;

   // Register map
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_BETA   = 2'd1;

   // Strength register, unsigned Q0.16
   localparam int BETA_WIDTH = 16;
   localparam logic [BETA_WIDTH-1:0] BETA_RESET = 16'd1311;
   localparam logic [BETA_WIDTH:0]   BETA_ONE   = 17'd65536;

   // pi/2 in Q30, used to build the quarter-wave table
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ----- rtl/core/spectral_gain_post_filter.sv -----
// Spectral post-filter: per-bin gain, sine shaping and bin scaling.
// Takes one bin per cycle while no result waits under stall.
// Depth is set by the one-bit-per-stage square roots and the two radix-2 dividers.
// The whole pipeline holds while a result waits under stall.
// Synchronous active-high reset clears valid bits and configuration registers
// (enable off, beta 1311); no clearing pass. Uses sgpf_pkg.
module spectral_gain_post_filter #(
   parameter int SAMPLE_WIDTH     = 24,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int GAIN_FRAC_BITS   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_enhanced_real,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_enhanced_imag,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_noisy_real,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_noisy_imag,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_filtered_real,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_filtered_imag,
   output logic [GAIN_FRAC_BITS:0]                rsp_applied_gain,
   input  logic                                   csr_write,
   input  logic [sgpf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sgpf_pkg::BETA_WIDTH-1:0]        csr_wdata
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int F   = GAIN_FRAC_BITS;
   localparam int BW  = sgpf_pkg::BETA_WIDTH;
   localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PW  = F + 2 + IW;
   localparam int NW  = F + 18;
   localparam logic [F:0] ONE = (F+1)'(1) << F;

   // Stage positions
   localparam int SQ0 = 3;
   localparam int DV0 = SQ0 + SW;
   localparam int GI  = DV0 + F;
   localparam int TB  = GI + 1;
   localparam int S2  = TB + 1;
   localparam int ND  = S2 + 1;
   localparam int PD0 = ND + 1;
   localparam int ML  = PD0 + F;
   localparam int OS  = ML + 1;
   localparam int L   = OS + 1;

   // Quarter-wave entry, evaluated at elaboration
   function automatic logic [F:0] sine_entry(input int unsigned idx);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      logic [63:0] s;
      x    = (sgpf_pkg::HALF_PI_Q30 * 64'(idx) + 64'(SINE_TABLE_DEPTH / 2))
             / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      s = (64'(sum) + (64'd1 << (29 - F))) >> (30 - F);
      if (s > 64'(ONE)) s = 64'(ONE);
      if (s < 64'd1) s = 64'd1;
      return s[F:0];
   endfunction

   logic [F:0] sine_rom [0:SINE_TABLE_DEPTH];
   for (genvar t = 0; t <= SINE_TABLE_DEPTH; t++) begin : g_rom
      assign sine_rom[t] = sine_entry(t);
   end

   // Configuration registers
   logic          enable_ff;
   logic [BW-1:0] beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         beta_ff   <= sgpf_pkg::BETA_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sgpf_pkg::CSR_IDX_ENABLE: enable_ff <= csr_wdata[0];
            sgpf_pkg::CSR_IDX_BETA:   beta_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline unless a result waits under stall
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Valid bits and per-item side data travel along every stage
   logic          vld_ff  [L];
   logic          cen_ff  [L];
   logic [BW-1:0] cbeta_ff[L];
   logic          csr_ff  [L];
   logic          csi_ff  [L];
   logic [SW-1:0] car_ff  [L];
   logic [SW-1:0] cai_ff  [L];

   logic [SW-1:0] nar_ff;
   logic [SW-1:0] nai_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < L; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Take absolute values and capture settings with the transfer
   always_ff @(posedge clock) begin
      if (adv) begin
         cen_ff[0]   <= enable_ff;
         cbeta_ff[0] <= beta_ff;
         csr_ff[0]   <= req_enhanced_real[SW-1];
         csi_ff[0]   <= req_enhanced_imag[SW-1];
         car_ff[0]   <= req_enhanced_real[SW-1] ? (~req_enhanced_real + 1'b1)
                                                 : req_enhanced_real;
         cai_ff[0]   <= req_enhanced_imag[SW-1] ? (~req_enhanced_imag + 1'b1)
                                                 : req_enhanced_imag;
         nar_ff      <= req_noisy_real[SW-1] ? (~req_noisy_real + 1'b1) : req_noisy_real;
         nai_ff      <= req_noisy_imag[SW-1] ? (~req_noisy_imag + 1'b1) : req_noisy_imag;
         for (int k = 1; k < L; k++) begin
            cen_ff[k]   <= cen_ff[k-1];
            cbeta_ff[k] <= cbeta_ff[k-1];
            csr_ff[k]   <= csr_ff[k-1];
            csi_ff[k]   <= csi_ff[k-1];
            car_ff[k]   <= car_ff[k-1];
            cai_ff[k]   <= cai_ff[k-1];
         end
      end
   end

   // Squares, then sums of squares
   logic [2*SW-1:0] sq_ff [4];
   logic [2*SW-1:0] sum_ff[2];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0]  <= (2*SW)'(car_ff[0]) * (2*SW)'(car_ff[0]);
         sq_ff[1]  <= (2*SW)'(cai_ff[0]) * (2*SW)'(cai_ff[0]);
         sq_ff[2]  <= (2*SW)'(nar_ff) * (2*SW)'(nar_ff);
         sq_ff[3]  <= (2*SW)'(nai_ff) * (2*SW)'(nai_ff);
         sum_ff[0] <= sq_ff[0] + sq_ff[1];
         sum_ff[1] <= sq_ff[2] + sq_ff[3];
      end
   end

   // Square roots, one result bit per stage (0 enhanced, 1 noisy)
   logic [2*SW-1:0] sqv_ff[2][SW];
   logic [SW-1:0]   sqr_ff[2][SW];
   logic [SW+2:0]   sqm_ff[2][SW];

   for (genvar m = 0; m < 2; m++) begin : g_mag
      for (genvar j = 0; j < SW; j++) begin : g_sqrt
         logic [2*SW-1:0] v_in;
         logic [SW-1:0]   r_in;
         logic [SW+2:0]   m_in;
         logic [SW+2:0]   remx;
         logic [SW+2:0]   trial;
         if (j == 0) begin : g_first
            assign v_in = sum_ff[m];
            assign r_in = '0;
            assign m_in = '0;
         end else begin : g_next
            assign v_in = sqv_ff[m][j-1];
            assign r_in = sqr_ff[m][j-1];
            assign m_in = sqm_ff[m][j-1];
         end
         assign remx  = {m_in[SW:0], v_in[2*SW-1:2*SW-2]};
         assign trial = {1'b0, r_in, 2'b01};
         always_ff @(posedge clock) begin
            if (adv) begin
               sqv_ff[m][j] <= {v_in[2*SW-3:0], 2'b00};
               if (remx >= trial) begin
                  sqm_ff[m][j] <= remx - trial;
                  sqr_ff[m][j] <= {r_in[SW-2:0], 1'b1};
               end else begin
                  sqm_ff[m][j] <= remx;
                  sqr_ff[m][j] <= {r_in[SW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // Gain ratio |e|/|n| by restoring division, one quotient bit per stage
   logic [SW-1:0] gdr_ff[F];
   logic [SW-1:0] gdd_ff[F];
   logic [F-1:0]  gq_ff [F];
   logic          gfx_ff[F];
   logic [F:0]    gfv_ff[F];

   for (genvar j = 0; j < F; j++) begin : g_gdiv
      logic [SW-1:0] r_in;
      logic [SW-1:0] d_in;
      logic [F-1:0]  q_in;
      logic          fx_in;
      logic [F:0]    fv_in;
      logic [SW:0]   remx;
      if (j == 0) begin : g_first
         logic [SW-1:0] me;
         logic [SW-1:0] mn;
         assign me    = sqr_ff[0][SW-1];
         assign mn    = sqr_ff[1][SW-1];
         assign r_in  = me;
         assign d_in  = mn;
         assign q_in  = '0;
         assign fx_in = (mn == '0) || (me >= mn);
         assign fv_in = ((mn == '0) && (me == '0)) ? (F+1)'(1) : ONE;
      end else begin : g_next
         assign r_in  = gdr_ff[j-1];
         assign d_in  = gdd_ff[j-1];
         assign q_in  = gq_ff[j-1];
         assign fx_in = gfx_ff[j-1];
         assign fv_in = gfv_ff[j-1];
      end
      assign remx = {r_in, 1'b0};
      always_ff @(posedge clock) begin
         if (adv) begin
            gdd_ff[j] <= d_in;
            gfx_ff[j] <= fx_in;
            gfv_ff[j] <= fv_in;
            if (remx >= {1'b0, d_in}) begin
               gdr_ff[j] <= SW'(remx - {1'b0, d_in});
               gq_ff[j]  <= {q_in[F-2:0], 1'b1};
            end else begin
               gdr_ff[j] <= remx[SW-1:0];
               gq_ff[j]  <= {q_in[F-2:0], 1'b0};
            end
         end
      end
   end

   // Table index, sine lookup, s squared
   logic [F:0]    gain_in;
   logic [PW-1:0] idx_prod;
   logic [IW-1:0] idx_ff;
   logic [F:0]    s_ff;
   logic [2*F+1:0] s_sq;
   logic [F:0]    s2_ff;

   always_comb begin
      if (gfx_ff[F-1])         gain_in = gfv_ff[F-1];
      else if (gq_ff[F-1] == '0) gain_in = (F+1)'(1);
      else                     gain_in = {1'b0, gq_ff[F-1]};
      idx_prod = PW'(gain_in) * PW'(SINE_TABLE_DEPTH) + (PW'(1) << (F - 1));
   end

   assign s_sq = (2*F+2)'(s_ff) * (2*F+2)'(s_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff <= idx_prod[F+IW-1:F];
         s_ff   <= sine_rom[idx_ff];
         s2_ff  <= s_sq[2*F:F];
      end
   end

   // Numerator and divisor of the post-filter factor
   logic [NW-1:0] num_ff;
   logic [NW-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= NW'({1'b0, cbeta_ff[S2]} + sgpf_pkg::BETA_ONE) * NW'(s2_ff);
         den_ff <= (NW'(s2_ff) << 16) + (NW'(cbeta_ff[S2]) << F);
      end
   end

   // Post-filter factor by restoring division
   logic [NW-1:0] pdr_ff[F];
   logic [NW-1:0] pdd_ff[F];
   logic [F-1:0]  pq_ff [F];
   logic          pfx_ff[F];

   for (genvar j = 0; j < F; j++) begin : g_pdiv
      logic [NW-1:0] r_in;
      logic [NW-1:0] d_in;
      logic [F-1:0]  q_in;
      logic          fx_in;
      logic [NW:0]   remx;
      if (j == 0) begin : g_first
         assign r_in  = num_ff;
         assign d_in  = den_ff;
         assign q_in  = '0;
         assign fx_in = !cen_ff[ND] || (den_ff == '0) || (num_ff >= den_ff);
      end else begin : g_next
         assign r_in  = pdr_ff[j-1];
         assign d_in  = pdd_ff[j-1];
         assign q_in  = pq_ff[j-1];
         assign fx_in = pfx_ff[j-1];
      end
      assign remx = {r_in, 1'b0};
      always_ff @(posedge clock) begin
         if (adv) begin
            pdd_ff[j] <= d_in;
            pfx_ff[j] <= fx_in;
            if (remx >= {1'b0, d_in}) begin
               pdr_ff[j] <= NW'(remx - {1'b0, d_in});
               pq_ff[j]  <= {q_in[F-2:0], 1'b1};
            end else begin
               pdr_ff[j] <= remx[NW-1:0];
               pq_ff[j]  <= {q_in[F-2:0], 1'b0};
            end
         end
      end
   end

   // Scale the enhanced magnitudes, then round and restore signs
   logic [F:0]      pf_in;
   logic [F:0]      pf_ff;
   logic [SW+F:0]   pr_ff;
   logic [SW+F:0]   pi_ff;
   logic [SW+F:0]   rr;
   logic [SW+F:0]   ri;
   logic [SW-1:0]   out_re_ff;
   logic [SW-1:0]   out_im_ff;
   logic [F:0]      out_pf_ff;

   assign pf_in = pfx_ff[F-1] ? ONE : {1'b0, pq_ff[F-1]};
   assign rr    = (pr_ff + (SW+F+1)'(ONE >> 1)) >> F;
   assign ri    = (pi_ff + (SW+F+1)'(ONE >> 1)) >> F;

   always_ff @(posedge clock) begin
      if (adv) begin
         pf_ff     <= pf_in;
         pr_ff     <= (SW+F+1)'(car_ff[PD0+F-1]) * (SW+F+1)'(pf_in);
         pi_ff     <= (SW+F+1)'(cai_ff[PD0+F-1]) * (SW+F+1)'(pf_in);
         out_re_ff <= csr_ff[ML] ? (SW'(0) - rr[SW-1:0]) : rr[SW-1:0];
         out_im_ff <= csi_ff[ML] ? (SW'(0) - ri[SW-1:0]) : ri[SW-1:0];
         out_pf_ff <= pf_ff;
      end
   end

   assign rsp_valid         = vld_ff[OS];
   assign rsp_filtered_real = out_re_ff;
   assign rsp_filtered_imag = out_im_ff;
   assign rsp_applied_gain  = out_pf_ff;

endmodule
